[sv/blinn_phong_shader_assert.svh]
// Assertion macros for the shader block.
`ifndef BLINN_PHONG_SHADER_ASSERT_SVH
`define BLINN_PHONG_SHADER_ASSERT_SVH

`ifndef SYNTHESIS
`define BPS_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("assertion failed");
`define BPS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("assertion failed");
`else
`define BPS_ASSERT_IMPL(label, clk, rst_n, cond, expr)
`define BPS_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

[sv/bps_pkg.sv]
// Shared types and constants of the shader block.
package bps_pkg;
	localparam int VEC_W  = 16;
	localparam int HH_W   = 34;
	localparam int NH_W   = 34;
	localparam int AMB_W  = 32;
	localparam int DEN_W  = 49;
	localparam int SPEC_W = 41;
	localparam int COL_W  = 8;
	localparam int OUT_W  = 16;

	localparam logic [SPEC_W-1:0] SPEC_CAP = SPEC_W'(1) << 40;

	localparam logic [1:0] CFG_AMBIENT   = 2'd0;
	localparam logic [1:0] CFG_LINEAR    = 2'd1;
	localparam logic [1:0] CFG_QUADRATIC = 2'd2;

	localparam logic [15:0] RST_AMBIENT   = 16'd3277;
	localparam logic [15:0] RST_LINEAR    = 16'd5898;
	localparam logic [15:0] RST_QUADRATIC = 16'd2097;

	typedef struct packed {
		logic [15:0] ambient;
		logic [15:0] linear;
		logic [15:0] quadratic;
	} cfg_regs_t;
endpackage

[sv/blinn_phong_shader.sv]
// Top level of the Blinn-Phong shader pipeline.
//
// channel  | direction | handshake                | contents
// s_axis   | in        | tvalid / tready          | one surface hit
// m_axis   | out       | tvalid / tready          | color and shaded intensity
// cfg      | in        | cfg_valid / cfg_ready    | register index and value
//
// One item per cycle while the output is not held; the pipeline runs through the front stages,
// the square root, the two dividers (one bit per stage) and the squaring chain.
// Reset clears valid bits and loads the register defaults.
// A held output stalls every stage at once; nothing is lost or repeated.
`include "blinn_phong_shader_assert.svh"
module blinn_phong_shader #(
	parameter int SHININESS_LOG2 = 6,
	parameter int VEC_FRAC_BITS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// light_dir_x/y/z, view_dir_x/y/z, normal_x/y/z, surface_brightness,
	// hit_distance, surface_color
	input  logic [183:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_color, intensity
	output logic [23:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import bps_pkg::*;

	localparam int DIF_W  = 64 - 2 * VEC_FRAC_BITS;
	localparam int SUM_W  = ((DIF_W > SPEC_W) ? DIF_W : SPEC_W) + 2;
	localparam int BASE_W = DEN_W + AMB_W + DIF_W + COL_W;
	localparam int N1_W   = NH_W + 38 - VEC_FRAC_BITS;
	localparam int X_W    = HH_W + 16;
	localparam int R_W    = X_W / 2;

	cfg_regs_t cfg_q;
	logic      adv;

	assign cfg_ready     = 1'b1;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ambient   <= RST_AMBIENT;
			cfg_q.linear    <= RST_LINEAR;
			cfg_q.quadratic <= RST_QUADRATIC;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_AMBIENT:   cfg_q.ambient   <= cfg_data;
				CFG_LINEAR:    cfg_q.linear    <= cfg_data;
				CFG_QUADRATIC: cfg_q.quadratic <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	logic               f_valid, f_use;
	logic [HH_W-1:0]    f_hh;
	logic [NH_W-1:0]    f_nh;
	logic [AMB_W-1:0]   f_amb;
	logic [DIF_W-1:0]   f_dif;
	logic [DEN_W-1:0]   f_den;
	logic [COL_W-1:0]   f_color;

	bps_front #(.VEC_FRAC_BITS(VEC_FRAC_BITS), .DIF_W(DIF_W)) u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .cfg(cfg_q),
		.in_valid(s_axis_tvalid && adv),
		.lx_in(s_axis_tdata[15:0]), .ly_in(s_axis_tdata[31:16]),
		.lz_in(s_axis_tdata[47:32]), .vx_in(s_axis_tdata[63:48]),
		.vy_in(s_axis_tdata[79:64]), .vz_in(s_axis_tdata[95:80]),
		.nx_in(s_axis_tdata[111:96]), .ny_in(s_axis_tdata[127:112]),
		.nz_in(s_axis_tdata[143:128]), .bright_in(s_axis_tdata[159:144]),
		.dist_in(s_axis_tdata[175:160]), .color_in(s_axis_tdata[183:176]),
		.out_valid(f_valid), .hh(f_hh), .nh_mag(f_nh), .use_spec(f_use),
		.ambient(f_amb), .diffuse(f_dif), .den(f_den), .color(f_color)
	);

	logic                      r_valid;
	logic [R_W-1:0]            r_root;
	logic [NH_W+BASE_W:0]      r_side;

	bps_isqrt #(.X_W(X_W), .SIDE_W(NH_W + BASE_W + 1)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(f_valid),
		.x_in({f_hh, 16'b0}),
		.side_in({f_nh, f_use, f_den, f_amb, f_dif, f_color}),
		.out_valid(r_valid), .root(r_root), .side_out(r_side)
	);

	logic [NH_W-1:0]   r_nh;
	logic              r_use;
	logic [BASE_W-1:0] r_base;
	logic [N1_W-1:0]   d1_num;
	assign r_nh   = r_side[NH_W+BASE_W:BASE_W+1];
	assign r_use  = r_side[BASE_W];
	assign r_base = r_side[BASE_W-1:0];
	assign d1_num = r_use ? (N1_W'(r_nh) << (38 - VEC_FRAC_BITS)) : '0;

	logic              d1_valid, d1_ovf;
	logic [SPEC_W-1:0] d1_quot;
	logic [BASE_W:0]   d1_side;

	bps_div #(.N_W(N1_W), .D_W(R_W), .Q_W(SPEC_W), .SIDE_W(BASE_W + 1)) u_div_spec (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(r_valid),
		.num(d1_num), .den(r_root), .side_in({r_use, r_base}),
		.out_valid(d1_valid), .quot(d1_quot), .ovf(d1_ovf), .side_out(d1_side)
	);

	logic [SPEC_W-1:0] base_t;
	always_comb begin
		if (!d1_side[BASE_W]) begin
			base_t = '0;
		end else if (d1_ovf || d1_quot > SPEC_CAP) begin
			base_t = SPEC_CAP;
		end else begin
			base_t = d1_quot;
		end
	end

	logic              p_valid;
	logic [SPEC_W-1:0] p_spec;
	logic [BASE_W-1:0] p_base;

	bps_spec #(.SHININESS_LOG2(SHININESS_LOG2), .SIDE_W(BASE_W)) u_spec (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(d1_valid),
		.t_in(base_t), .side_in(d1_side[BASE_W-1:0]),
		.out_valid(p_valid), .spec(p_spec), .side_out(p_base)
	);

	logic [DEN_W-1:0] p_den;
	logic [AMB_W-1:0] p_amb;
	logic [DIF_W-1:0] p_dif;
	logic [COL_W-1:0] p_color;
	assign {p_den, p_amb, p_dif, p_color} = p_base;

	logic             valid_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [DEN_W-1:0] den_s1;
	logic [COL_W-1:0] color_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= p_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1   <= SUM_W'(p_amb) + SUM_W'(p_dif) + SUM_W'(p_spec);
			den_s1   <= p_den;
			color_s1 <= p_color;
		end
	end

	logic             d2_ovf;
	logic [OUT_W-1:0] d2_quot;
	logic [COL_W-1:0] d2_color;

	bps_div #(.N_W(SUM_W + 15), .D_W(DEN_W), .Q_W(OUT_W), .SIDE_W(COL_W)) u_div_att (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(valid_s1),
		.num({sum_s1, 15'b0}), .den(den_s1), .side_in(color_s1),
		.out_valid(m_axis_tvalid), .quot(d2_quot), .ovf(d2_ovf), .side_out(d2_color)
	);

	assign m_axis_tdata = {(d2_ovf ? {OUT_W{1'b1}} : d2_quot), d2_color};

	`BPS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`BPS_ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`BPS_ASSERT_IMPL(a_ready_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)
endmodule

[sv/bps_front.sv]
// Front stages: dot products, halfway vector, ambient, diffuse and divisor.
module bps_front #(
	parameter int VEC_FRAC_BITS = 14,
	parameter int DIF_W = 36
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  bps_pkg::cfg_regs_t    cfg,
	input  logic                  in_valid,
	input  logic [15:0]           lx_in,
	input  logic [15:0]           ly_in,
	input  logic [15:0]           lz_in,
	input  logic [15:0]           vx_in,
	input  logic [15:0]           vy_in,
	input  logic [15:0]           vz_in,
	input  logic [15:0]           nx_in,
	input  logic [15:0]           ny_in,
	input  logic [15:0]           nz_in,
	input  logic [15:0]           bright_in,
	input  logic [15:0]           dist_in,
	input  logic [7:0]            color_in,
	output logic                  out_valid,
	output logic [33:0]           hh,
	output logic [33:0]           nh_mag,
	output logic                  use_spec,
	output logic [31:0]           ambient,
	output logic [DIF_W-1:0]      diffuse,
	output logic [48:0]           den,
	output logic [7:0]            color
);
	import bps_pkg::*;

	localparam int DIF_SH = 2 * VEC_FRAC_BITS - 16;

	logic signed [15:0] lx, ly, lz, vx, vy, vz, nx, ny, nz;
	assign lx = $signed(lx_in);
	assign ly = $signed(ly_in);
	assign lz = $signed(lz_in);
	assign vx = $signed(vx_in);
	assign vy = $signed(vy_in);
	assign vz = $signed(vz_in);
	assign nx = $signed(nx_in);
	assign ny = $signed(ny_in);
	assign nz = $signed(nz_in);

	logic               valid_s1, valid_s2, valid_s3;
	logic signed [31:0] p0_s1, p1_s1, p2_s1;
	logic signed [16:0] hx_s1, hy_s1, hz_s1;
	logic signed [15:0] nx_s1, ny_s1, nz_s1;
	logic [31:0]        amb_s1, ad_s1, dd_s1;
	logic [15:0]        bright_s1;
	logic [7:0]         color_s1;

	logic signed [33:0] ln_s2;
	logic [33:0]        h0_s2, h1_s2, h2_s2;
	logic signed [32:0] n0_s2, n1_s2, n2_s2;
	logic [47:0]        bd_s2;
	logic [31:0]        ad_s2, amb_s2;
	logic [15:0]        bright_s2;
	logic [7:0]         color_s2;

	logic [33:0]        hh_s3;
	logic signed [34:0] nh_s3;
	logic               lnpos_s3;
	logic [DIF_W-1:0]   dif_s3;
	logic [48:0]        den_s3;
	logic [31:0]        amb_s3;
	logic [7:0]         color_s3;
	logic [47:0]        dif_prod;

	assign dif_prod = 48'(ln_s2[31:0]) * 48'(bright_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s1     <= 32'(lx) * 32'(nx);
			p1_s1     <= 32'(ly) * 32'(ny);
			p2_s1     <= 32'(lz) * 32'(nz);
			hx_s1     <= 17'(lx) + 17'(vx);
			hy_s1     <= 17'(ly) + 17'(vy);
			hz_s1     <= 17'(lz) + 17'(vz);
			nx_s1     <= nx;
			ny_s1     <= ny;
			nz_s1     <= nz;
			amb_s1    <= 32'(cfg.ambient) * 32'(bright_in);
			ad_s1     <= 32'(cfg.linear) * 32'(dist_in);
			dd_s1     <= 32'(dist_in) * 32'(dist_in);
			bright_s1 <= bright_in;
			color_s1  <= color_in;

			ln_s2     <= 34'(p0_s1) + 34'(p1_s1) + 34'(p2_s1);
			h0_s2     <= 34'(34'(hx_s1) * 34'(hx_s1));
			h1_s2     <= 34'(34'(hy_s1) * 34'(hy_s1));
			h2_s2     <= 34'(34'(hz_s1) * 34'(hz_s1));
			n0_s2     <= 33'(nx_s1) * 33'(hx_s1);
			n1_s2     <= 33'(ny_s1) * 33'(hy_s1);
			n2_s2     <= 33'(nz_s1) * 33'(hz_s1);
			bd_s2     <= 48'(cfg.quadratic) * 48'(dd_s1);
			ad_s2     <= ad_s1;
			amb_s2    <= amb_s1;
			bright_s2 <= bright_s1;
			color_s2  <= color_s1;

			hh_s3     <= h0_s2 + h1_s2 + h2_s2;
			nh_s3     <= 35'(n0_s2) + 35'(n1_s2) + 35'(n2_s2);
			lnpos_s3  <= (ln_s2 > 34'sd0);
			dif_s3    <= (ln_s2 > 34'sd0) ? DIF_W'(dif_prod >> DIF_SH) : '0;
			den_s3    <= (49'(1) << 32) + 49'({ad_s2, 8'b0}) + 49'(bd_s2);
			amb_s3    <= amb_s2;
			color_s3  <= color_s2;
		end
	end

	assign out_valid = valid_s3;
	assign hh        = hh_s3;
	assign nh_mag    = nh_s3[33:0];
	assign use_spec  = lnpos_s3 && (hh_s3 != '0) && (nh_s3 > 35'sd0);
	assign ambient   = amb_s3;
	assign diffuse   = dif_s3;
	assign den       = den_s3;
	assign color     = color_s3;
endmodule

[sv/bps_isqrt.sv]
// Pipelined floor square root, one result bit per stage.
module bps_isqrt #(
	parameter int X_W = 50,
	parameter int SIDE_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic [X_W-1:0]      x_in,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                out_valid,
	output logic [X_W/2-1:0]    root,
	output logic [SIDE_W-1:0]   side_out
);
	localparam int K = X_W / 2;

	logic              valid_s [0:K];
	logic [X_W-1:0]    x_s     [0:K];
	logic [X_W-1:0]    r_s     [0:K];
	logic [SIDE_W-1:0] side_s  [0:K];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]    <= x_in;
			r_s[0]    <= '0;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < K; k++) begin : g_stage
		localparam logic [X_W:0] BIT = (X_W+1)'(1) << (X_W - 2 - 2 * k);
		logic [X_W:0] trial;
		assign trial = {1'b0, r_s[k]} + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if ({1'b0, x_s[k]} >= trial) begin
					x_s[k+1] <= X_W'({1'b0, x_s[k]} - trial);
					r_s[k+1] <= X_W'(({1'b0, r_s[k]} >> 1) + BIT);
				end else begin
					x_s[k+1] <= x_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[K];
	assign root      = r_s[K][X_W/2-1:0];
	assign side_out  = side_s[K];
endmodule

[sv/bps_div.sv]
// Pipelined restoring divider with overflow flag, one quotient bit per stage.
module bps_div #(
	parameter int N_W = 58,
	parameter int D_W = 49,
	parameter int Q_W = 16,
	parameter int SIDE_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [N_W-1:0]     num,
	input  logic [D_W-1:0]     den,
	input  logic [SIDE_W-1:0]  side_in,
	output logic               out_valid,
	output logic [Q_W-1:0]     quot,
	output logic               ovf,
	output logic [SIDE_W-1:0]  side_out
);
	localparam int C_W = (N_W > D_W) ? N_W : D_W;

	logic              valid_s [0:Q_W];
	logic [D_W-1:0]    rem_s   [0:Q_W];
	logic [Q_W-1:0]    low_s   [0:Q_W];
	logic [Q_W-1:0]    q_s     [0:Q_W];
	logic [D_W-1:0]    den_s   [0:Q_W];
	logic              ovf_s   [0:Q_W];
	logic [SIDE_W-1:0] side_s  [0:Q_W];

	logic [C_W-1:0] hi_c;
	logic           ovf_c;
	assign hi_c  = C_W'(num >> Q_W);
	assign ovf_c = hi_c >= C_W'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= ovf_c ? '0 : D_W'(hi_c);
			low_s[0]  <= num[Q_W-1:0];
			q_s[0]    <= '0;
			den_s[0]  <= den;
			ovf_s[0]  <= ovf_c;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [D_W:0] t;
		logic         ge;
		assign t  = {rem_s[k], low_s[k][Q_W-1]};
		assign ge = t >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= ge ? D_W'(t - {1'b0, den_s[k]}) : D_W'(t);
				low_s[k+1]  <= low_s[k] << 1;
				q_s[k+1]    <= {q_s[k][Q_W-2:0], ge};
				den_s[k+1]  <= den_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[Q_W];
	assign quot      = q_s[Q_W];
	assign ovf       = ovf_s[Q_W];
	assign side_out  = side_s[Q_W];
endmodule

[sv/bps_spec.sv]
// Specular power: repeated saturating squares, one multiply per stage.
module bps_spec #(
	parameter int SHININESS_LOG2 = 6,
	parameter int SIDE_W = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  logic [bps_pkg::SPEC_W-1:0] t_in,
	input  logic [SIDE_W-1:0]          side_in,
	output logic                       out_valid,
	output logic [bps_pkg::SPEC_W-1:0] spec,
	output logic [SIDE_W-1:0]          side_out
);
	import bps_pkg::*;

	logic              valid_s [0:SHININESS_LOG2];
	logic [SPEC_W-1:0] t_s     [0:SHININESS_LOG2];
	logic [SIDE_W-1:0] side_s  [0:SHININESS_LOG2];

	assign valid_s[0] = in_valid;
	assign t_s[0]     = t_in;
	assign side_s[0]  = side_in;

	for (genvar k = 0; k < SHININESS_LOG2; k++) begin : g_stage
		logic [63:0] prod;
		logic        big;
		assign prod = 64'(t_s[k][31:0]) * 64'(t_s[k][31:0]);
		assign big  = t_s[k][SPEC_W-1:32] != '0;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				t_s[k+1]    <= big ? SPEC_CAP : SPEC_W'(prod >> 30);
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[SHININESS_LOG2];
	assign spec      = t_s[SHININESS_LOG2];
	assign side_out  = side_s[SHININESS_LOG2];
endmodule
